/* design/cpda_pkg.sv */
// ----------------------------------------------------------------------------
// cpda_pkg
// Shared types, codes and constants of the capacity priority dispatch arbiter.
// ----------------------------------------------------------------------------
package cpda_pkg;

    // Default sizing handed to the top level.
    localparam int MAX_DEVICES_DEFAULT = 4;
    localparam int COUNT_WIDTH_DEFAULT = 16;

    // Fixed register file layout.
    localparam int SETUP_REGS    = 4;
    localparam int SETUP_W       = 48;
    localparam int FIELD_W       = 16;
    localparam int DEV_W         = 2;
    localparam int COUNT_REG_W   = 3;
    localparam int DATA_W        = 64;
    localparam int ADDR_W        = 6;
    localparam int REG_IDX_W     = 3;
    localparam int SCAN_IDX_W    = $clog2(SETUP_REGS);

    localparam logic [COUNT_REG_W-1:0] DEVICE_COUNT_RESET = 3'd4;
    localparam logic [SETUP_W-1:0]     SETUP_RESET        = 48'h0001_0001_0001;

    // Register indexes (address bits 5:3).
    localparam logic [REG_IDX_W-1:0] REG_DEVICE_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DEV0_SETUP   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DEV3_SETUP   = 3'd4;

    typedef enum logic [1:0] {
        FUNC_QUERY    = 2'd0,
        FUNC_DISPATCH = 2'd1,
        FUNC_COMPLETE = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_OVERSUB  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_UNKNOWN  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [COUNT_REG_W-1:0]             device_count;
        logic [SETUP_REGS-1:0][SETUP_W-1:0] setup;
    } cfg_t;

    typedef struct packed {
        logic                  capture;
        logic                  scan;
        logic                  update;
        logic                  finish;
        logic [SCAN_IDX_W-1:0] scan_idx;
    } cmd_t;

    typedef struct packed {
        logic query_req;
    } status_t;

    function automatic logic [FIELD_W-1:0] setup_batch(input logic [SETUP_W-1:0] s);
        return s[15:0];
    endfunction

    function automatic logic [FIELD_W-1:0] setup_cap(input logic [SETUP_W-1:0] s);
        return s[31:16];
    endfunction

    function automatic logic [FIELD_W-1:0] setup_pri(input logic [SETUP_W-1:0] s);
        return s[47:32];
    endfunction

endpackage

/* design/cpda_cfg.sv */
// ----------------------------------------------------------------------------
// cpda_cfg
// APB register file holding the device count and the four device setups.
// ----------------------------------------------------------------------------
module cpda_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cpda_pkg::ADDR_W-1:0]    paddr,
    input  logic [cpda_pkg::DATA_W-1:0]    pwdata,
    output logic [cpda_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output cpda_pkg::cfg_t                 cfg
);

    logic [cpda_pkg::COUNT_REG_W-1:0] count_reg;
    logic [cpda_pkg::SETUP_REGS-1:0][cpda_pkg::SETUP_W-1:0] setup_reg;
    logic [cpda_pkg::REG_IDX_W-1:0] reg_idx;
    logic [cpda_pkg::REG_IDX_W-1:0] setup_off;
    logic wr_en;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[cpda_pkg::ADDR_W-1:3];
    assign setup_off = reg_idx - cpda_pkg::REG_DEV0_SETUP;
    assign wr_en     = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= cpda_pkg::DEVICE_COUNT_RESET;
            for (int i = 0; i < cpda_pkg::SETUP_REGS; i++)
            begin
                setup_reg[i] <= cpda_pkg::SETUP_RESET;
            end
        end
        else if (wr_en)
        begin
            if (reg_idx == cpda_pkg::REG_DEVICE_COUNT)
            begin
                count_reg <= pwdata[cpda_pkg::COUNT_REG_W-1:0];
            end
            else if (reg_idx <= cpda_pkg::REG_DEV3_SETUP)
            begin
                setup_reg[setup_off[cpda_pkg::SCAN_IDX_W-1:0]] <=
                    pwdata[cpda_pkg::SETUP_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == cpda_pkg::REG_DEVICE_COUNT)
        begin
            prdata = cpda_pkg::DATA_W'(count_reg);
        end
        else if (reg_idx <= cpda_pkg::REG_DEV3_SETUP)
        begin
            prdata = cpda_pkg::DATA_W'(setup_reg[setup_off[cpda_pkg::SCAN_IDX_W-1:0]]);
        end
    end

    assign cfg.device_count = count_reg;
    assign cfg.setup        = setup_reg;

endmodule

/* design/cpda_ctrl.sv */
// ----------------------------------------------------------------------------
// cpda_ctrl
// Sequencer: accepts a command, steps the device scan or the load update,
// and triggers the result.
// ----------------------------------------------------------------------------
module cpda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  cpda_pkg::status_t   status,
    output logic                busy,
    output cpda_pkg::cmd_t      cmd
);

    localparam logic [cpda_pkg::SCAN_IDX_W-1:0] SCAN_LAST =
        cpda_pkg::SCAN_IDX_W'(cpda_pkg::SETUP_REGS - 1);

    cpda_pkg::state_t state_reg, state_next;
    logic [cpda_pkg::SCAN_IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpda_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            cpda_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    state_next = status.query_req ? cpda_pkg::ST_SCAN : cpda_pkg::ST_UPDATE;
                end
            end
            cpda_pkg::ST_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SCAN_LAST)
                begin
                    state_next = cpda_pkg::ST_FINISH;
                end
            end
            cpda_pkg::ST_UPDATE:
            begin
                state_next = cpda_pkg::ST_FINISH;
            end
            cpda_pkg::ST_FINISH:
            begin
                state_next = cpda_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cpda_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd          = '0;
        cmd.scan_idx = cnt_reg;
        busy         = 1'b1;
        unique case (state_reg)
            cpda_pkg::ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            cpda_pkg::ST_SCAN:   cmd.scan   = 1'b1;
            cpda_pkg::ST_UPDATE: cmd.update = 1'b1;
            cpda_pkg::ST_FINISH: cmd.finish = 1'b1;
            default:             busy       = 1'b1;
        endcase
    end

endmodule

/* design/cpda_dp.sv */
// ----------------------------------------------------------------------------
// cpda_dp
// Datapath: load counters, one-device-per-cycle capacity check with running
// priority maximum, load update and result registers.
// ----------------------------------------------------------------------------
module cpda_dp #(
    parameter int MAX_DEVICES = cpda_pkg::MAX_DEVICES_DEFAULT,
    parameter int COUNT_WIDTH = cpda_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cpda_pkg::cmd_t                      cmd,
    output cpda_pkg::status_t                   status,
    input  cpda_pkg::cfg_t                      cfg,
    input  logic [1:0]                          func,
    input  logic [cpda_pkg::DEV_W-1:0]          dev_index,
    input  logic [cpda_pkg::FIELD_W-1:0]        amount,
    output logic                                strobe,
    output logic                                available,
    output logic [cpda_pkg::DEV_W-1:0]          chosen_dev,
    output logic [cpda_pkg::FIELD_W-1:0]        chosen_batch,
    output logic [1:0]                          error_code,
    output logic                                all_idle
);

    // Sum width covers a load plus a 16-bit batch or amount without wrap.
    localparam int SUM_W = ((COUNT_WIDTH > cpda_pkg::FIELD_W) ?
                            COUNT_WIDTH : cpda_pkg::FIELD_W) + 1;
    localparam int DEV_LIMIT = (MAX_DEVICES < cpda_pkg::SETUP_REGS) ?
                               MAX_DEVICES : cpda_pkg::SETUP_REGS;

    logic [COUNT_WIDTH-1:0] load_reg  [MAX_DEVICES];
    logic [COUNT_WIDTH-1:0] load_next [MAX_DEVICES];

    logic [1:0]                   func_reg;
    logic [cpda_pkg::DEV_W-1:0]   dev_reg;
    logic [cpda_pkg::FIELD_W-1:0] amount_reg;

    logic                         avail_reg, avail_next;
    logic [cpda_pkg::FIELD_W-1:0] best_reg, best_next;
    logic [cpda_pkg::DEV_W-1:0]   chosen_reg, chosen_next;
    logic [cpda_pkg::FIELD_W-1:0] batch_reg, batch_next;
    logic [1:0]                   err_reg, err_next;

    logic                         strobe_reg;
    logic                         out_avail_reg;
    logic [cpda_pkg::DEV_W-1:0]   out_dev_reg;
    logic [cpda_pkg::FIELD_W-1:0] out_batch_reg;
    logic [1:0]                   out_err_reg;
    logic                         out_idle_reg;

    logic [cpda_pkg::COUNT_REG_W-1:0] n_active;
    logic [cpda_pkg::DEV_W-1:0]       rd_idx;
    logic [COUNT_WIDTH-1:0]           cur_load;
    logic [cpda_pkg::SETUP_W-1:0]     scan_setup;
    logic [cpda_pkg::SETUP_W-1:0]     upd_setup;
    logic [SUM_W-1:0]                 fit_sum;
    logic                             fits;
    logic [SUM_W-1:0]                 add_sum;
    logic [SUM_W-1:0]                 sub_diff;
    logic                             upd_we;
    logic [COUNT_WIDTH-1:0]           upd_val;
    logic                             idle_now;

    assign status.query_req = (func == cpda_pkg::FUNC_QUERY);

    // Devices in use: the register saturated to the number of devices built.
    always_comb
    begin
        if (int'(cfg.device_count) > DEV_LIMIT)
        begin
            n_active = cpda_pkg::COUNT_REG_W'(DEV_LIMIT);
        end
        else
        begin
            n_active = cfg.device_count;
        end
    end

    // One shared load read port: the scan index while scanning, else the item's device.
    assign rd_idx = cmd.scan ? cmd.scan_idx : dev_reg;

    always_comb
    begin
        cur_load = '0;
        for (int i = 0; i < MAX_DEVICES; i++)
        begin
            if (int'(rd_idx) == i)
            begin
                cur_load = load_reg[i];
            end
        end
    end

    assign scan_setup = cfg.setup[cmd.scan_idx];
    assign upd_setup  = cfg.setup[dev_reg];

    // Capacity check and running maximum for the device under scan.
    assign fit_sum = SUM_W'(cur_load) + SUM_W'(cpda_pkg::setup_batch(scan_setup));
    assign fits    = (fit_sum <= SUM_W'(cpda_pkg::setup_cap(scan_setup))) &&
                     (cpda_pkg::COUNT_REG_W'(cmd.scan_idx) < n_active);

    assign add_sum  = SUM_W'(cur_load) + SUM_W'(amount_reg);
    assign sub_diff = SUM_W'(cur_load) - SUM_W'(amount_reg);

    always_comb
    begin
        avail_next  = avail_reg;
        best_next   = best_reg;
        chosen_next = chosen_reg;
        batch_next  = batch_reg;
        err_next    = err_reg;
        upd_we      = 1'b0;
        upd_val     = cur_load;

        if (cmd.capture)
        begin
            avail_next  = 1'b0;
            best_next   = '0;
            chosen_next = '0;
            batch_next  = '0;
            err_next    = cpda_pkg::ERR_OK;
        end
        else if (cmd.scan)
        begin
            if (fits && (!avail_reg || cpda_pkg::setup_pri(scan_setup) > best_reg))
            begin
                avail_next  = 1'b1;
                best_next   = cpda_pkg::setup_pri(scan_setup);
                chosen_next = cmd.scan_idx;
                batch_next  = cpda_pkg::setup_batch(scan_setup);
            end
        end
        else if (cmd.update)
        begin
            if (func_reg == cpda_pkg::FUNC_DISPATCH || func_reg == cpda_pkg::FUNC_COMPLETE)
            begin
                if (cpda_pkg::COUNT_REG_W'(dev_reg) >= n_active)
                begin
                    err_next = cpda_pkg::ERR_UNKNOWN;
                end
                else if (func_reg == cpda_pkg::FUNC_DISPATCH)
                begin
                    if (add_sum > SUM_W'(cpda_pkg::setup_cap(upd_setup)) ||
                        (add_sum >> COUNT_WIDTH) != '0)
                    begin
                        err_next = cpda_pkg::ERR_OVERSUB;
                    end
                    else
                    begin
                        upd_we  = 1'b1;
                        upd_val = add_sum[COUNT_WIDTH-1:0];
                    end
                end
                else
                begin
                    if (SUM_W'(amount_reg) > SUM_W'(cur_load))
                    begin
                        err_next = cpda_pkg::ERR_UNDERFLOW;
                    end
                    else
                    begin
                        upd_we  = 1'b1;
                        upd_val = sub_diff[COUNT_WIDTH-1:0];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DEVICES; i++)
        begin
            load_next[i] = load_reg[i];
            if (upd_we && int'(dev_reg) == i)
            begin
                load_next[i] = upd_val;
            end
        end
    end

    // Loads of devices in use, all zero.
    always_comb
    begin
        idle_now = 1'b1;
        for (int i = 0; i < MAX_DEVICES; i++)
        begin
            if (i < int'(n_active) && load_reg[i] != '0)
            begin
                idle_now = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DEVICES; i++)
            begin
                load_reg[i] <= '0;
            end
            strobe_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < MAX_DEVICES; i++)
            begin
                load_reg[i] <= load_next[i];
            end
            strobe_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            dev_reg    <= dev_index;
            amount_reg <= amount;
        end
        avail_reg  <= avail_next;
        best_reg   <= best_next;
        chosen_reg <= chosen_next;
        batch_reg  <= batch_next;
        err_reg    <= err_next;
        if (cmd.finish)
        begin
            out_avail_reg <= avail_reg;
            out_dev_reg   <= chosen_reg;
            out_batch_reg <= batch_reg;
            out_err_reg   <= err_reg;
            out_idle_reg  <= idle_now;
        end
    end

    assign strobe       = strobe_reg;
    assign available    = out_avail_reg;
    assign chosen_dev   = out_dev_reg;
    assign chosen_batch = out_batch_reg;
    assign error_code   = out_err_reg;
    assign all_idle     = out_idle_reg;

endmodule

/* design/capacity_priority_dispatch_arbiter_top.sv */
// ----------------------------------------------------------------------------
// capacity_priority_dispatch_arbiter_top
// Load-tracking arbiter that picks the highest-priority device with room.
// ----------------------------------------------------------------------------
// Usage:
// A command is issued by raising start with func, dev_index and amount while
// busy is low; it is taken at that clock edge. A query (func 0) scans the
// four device setup slots, one per cycle, and picks among the devices in use
// whose load plus batch fits within capacity the one with the highest
// priority, the lowest index winning a tie. A dispatch (func 1) adds amount
// to the device's load and a completion (func 2) subtracts it; a request
// that would overflow, underflow or names a device not in use reports an
// error and leaves the load alone. Every command yields exactly one result,
// shown on the result ports for one cycle while done is high, including
// all_idle, which tells whether every load of a device in use is zero.
// A query scans the setup slots through the single shared capacity comparator,
// then passes the finish and output register stages; a dispatch or
// completion passes the update state in place of the scan.
// busy is low in the result cycle, so a new command can overlap delivery.
// The receiver cannot stall: a result is gone after its cycle.
// Reset clears all loads, sets the device count to four and every setup to
// batch 1, capacity 1, priority 1. Setup must be written over the APB port
// only while the block is idle, which the block does not enforce; pready is always high.
// ----------------------------------------------------------------------------
module capacity_priority_dispatch_arbiter_top #(
    parameter int MAX_DEVICES = cpda_pkg::MAX_DEVICES_DEFAULT,
    parameter int COUNT_WIDTH = cpda_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel.
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      func,
    input  logic [cpda_pkg::DEV_W-1:0]      dev_index,
    input  logic [cpda_pkg::FIELD_W-1:0]    amount,
    // Result channel.
    output logic                            done,
    output logic                            available,
    output logic [cpda_pkg::DEV_W-1:0]      chosen_dev,
    output logic [cpda_pkg::FIELD_W-1:0]    chosen_batch,
    output logic [1:0]                      error_code,
    output logic                            all_idle,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpda_pkg::ADDR_W-1:0]     paddr,
    input  logic [cpda_pkg::DATA_W-1:0]     pwdata,
    output logic [cpda_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    cpda_pkg::cfg_t    cfg;
    cpda_pkg::cmd_t    cmd;
    cpda_pkg::status_t status;

    // Register file for the device count and the per-device setups.
    cpda_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The sequencer decides which step the datapath takes each cycle.
    cpda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Loads, the scan comparator, the update adder and the result registers.
    cpda_dp #(
        .MAX_DEVICES (MAX_DEVICES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg          (cfg),
        .func         (func),
        .dev_index    (dev_index),
        .amount       (amount),
        .strobe       (done),
        .available    (available),
        .chosen_dev   (chosen_dev),
        .chosen_batch (chosen_batch),
        .error_code   (error_code),
        .all_idle     (all_idle)
    );

endmodule

/* sim/tb_capacity_priority_dispatch_arbiter_top.sv */
// ----------------------------------------------------------------------------
// tb_capacity_priority_dispatch_arbiter_top
// Self-checking bench for the capacity priority dispatch arbiter.
// ----------------------------------------------------------------------------
// Commands go out with random gaps or none, and the device count and setups
// are rewritten over APB between phases while the block is idle. A load
// ledger tracks per-device loads and predicts each result. Every done strobe
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_capacity_priority_dispatch_arbiter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cpda_pkg::*;

    // Longest command latency (a query) plus margin, used before setup writes
    // and at the end of the run.
    localparam int IDLE_GUARD     = 8;
    // Cycles in a row with no handshake of any kind before the run is abandoned.
    localparam int STALL_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 50;

    typedef struct packed {
        logic                 available;
        logic [DEV_W-1:0]     chosen_dev;
        logic [FIELD_W-1:0]   chosen_batch;
        logic [1:0]           error_code;
        logic                 all_idle;
    } result_t;

    // The ledger mirrors the block's loads and register file. note_command
    // updates the loads and queues the predicted result; check_result pops
    // the oldest prediction and compares it with what the block produced.
    class load_ledger;
        logic [COUNT_REG_W-1:0] device_count;
        logic [SETUP_W-1:0]     setup [SETUP_REGS];
        logic [FIELD_W-1:0]     dev_load [SETUP_REGS];
        result_t                expected_results [$];
        int                     failures;

        function new();
            device_count = DEVICE_COUNT_RESET;
            foreach (setup[i]) setup[i] = SETUP_RESET;
            foreach (dev_load[i]) dev_load[i] = '0;
            failures = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            if (idx == REG_DEVICE_COUNT)
                device_count = value[COUNT_REG_W-1:0];
            else if (idx >= REG_DEV0_SETUP && idx <= REG_DEV3_SETUP)
                setup[SCAN_IDX_W'(idx - REG_DEV0_SETUP)] = value[SETUP_W-1:0];
        endfunction

        function int devices_in_use();
            return (device_count > SETUP_REGS) ? SETUP_REGS : int'(device_count);
        endfunction

        function void note_command(func_t f, logic [DEV_W-1:0] dev, logic [FIELD_W-1:0] amt);
            result_t            r;
            int                 n;
            logic [FIELD_W:0]   sum;
            logic [FIELD_W-1:0] best;
            r = '0;
            best = '0;
            n = devices_in_use();
            if (f == FUNC_QUERY) begin
                for (int i = 0; i < n; i++) begin
                    sum = {1'b0, dev_load[i]} + {1'b0, setup[i][15:0]};
                    if (sum <= {1'b0, setup[i][31:16]}) begin
                        if (!r.available || setup[i][47:32] > best) begin
                            r.available    = 1'b1;
                            best           = setup[i][47:32];
                            r.chosen_dev   = DEV_W'(i);
                            r.chosen_batch = setup[i][15:0];
                        end
                    end
                end
            end else if (f == FUNC_DISPATCH || f == FUNC_COMPLETE) begin
                if (int'(dev) >= n) begin
                    r.error_code = ERR_UNKNOWN;
                end else if (f == FUNC_DISPATCH) begin
                    sum = {1'b0, dev_load[dev]} + {1'b0, amt};
                    if (sum > {1'b0, setup[dev][31:16]} || sum[FIELD_W])
                        r.error_code = ERR_OVERSUB;
                    else
                        dev_load[dev] = sum[FIELD_W-1:0];
                end else begin
                    if (amt > dev_load[dev])
                        r.error_code = ERR_UNDERFLOW;
                    else
                        dev_load[dev] = dev_load[dev] - amt;
                end
            end
            // Only devices in use count toward the idle flag.
            r.all_idle = 1'b1;
            for (int i = 0; i < n; i++)
                if (dev_load[i] != '0) r.all_idle = 1'b0;
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result with nothing pending: avail=%0d dev=%0d batch=%h",
                             got.available, got.chosen_dev, got.chosen_batch,
                             " err=%0d idle=%0d", got.error_code, got.all_idle);
                return;
            end
            want = expected_results.pop_front();
            if (got.available !== want.available || got.chosen_dev !== want.chosen_dev ||
                got.chosen_batch !== want.chosen_batch ||
                got.error_code !== want.error_code || got.all_idle !== want.all_idle) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("mismatch at %0t: expected avail=%0d dev=%0d batch=%h",
                             $realtime, want.available, want.chosen_dev, want.chosen_batch,
                             " err=%0d idle=%0d, got avail=%0d dev=%0d",
                             want.error_code, want.all_idle, got.available, got.chosen_dev,
                             " batch=%h err=%0d idle=%0d",
                             got.chosen_batch, got.error_code, got.all_idle);
            end
        endfunction
    endclass

    // Every input starts at a known value so nothing floats during reset.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [1:0]           func = '0;
    logic [DEV_W-1:0]     dev_index = '0;
    logic [FIELD_W-1:0]   amount = '0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;

    logic                 busy;
    logic                 done;
    logic                 available;
    logic [DEV_W-1:0]     chosen_dev;
    logic [FIELD_W-1:0]   chosen_batch;
    logic [1:0]           error_code;
    logic                 all_idle;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    load_ledger ledger;
    // When set, commands go out back to back with no gaps at all.
    bit                   no_gaps = 1'b0;
    int                   stall_cycles = 0;

    capacity_priority_dispatch_arbiter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .dev_index    (dev_index),
        .amount       (amount),
        .done         (done),
        .available    (available),
        .chosen_dev   (chosen_dev),
        .chosen_batch (chosen_batch),
        .error_code   (error_code),
        .all_idle     (all_idle),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Results cannot be held off, so every done strobe is checked at the
    // edge that closes its cycle. Values read here are the pre-edge ones.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            ledger.check_result({available, chosen_dev, chosen_batch, error_code, all_idle});
    end

    // The watchdog restarts on any command, result or register handshake.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_capacity_priority_dispatch_arbiter_top: done, errors");
            $finish;
        end
    end

    // Issues one item after a random gap and waits for the edge that takes it.
    // start is left high afterward so that a gapless next item keeps it high
    // instead of dropping and raising it in the same step.
    task automatic send_command(func_t f, logic [DEV_W-1:0] dev, logic [FIELD_W-1:0] amt);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        dev_index <= dev;
        amount    <= amt;
        do @(posedge clk); while (busy !== 1'b0);
        ledger.note_command(f, dev, amt);
    endtask

    // Holds off new items until every predicted result has been seen, then
    // lets the block settle for the length of its longest command.
    task automatic drain();
        start <= 1'b0;
        while (ledger.pending() != 0) @(posedge clk);
        repeat (IDLE_GUARD) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access cycle until pready. psel is
    // left high so that back-to-back writes need no extra assignments.
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        ledger.write_register(idx, value);
    endtask

    // Rewrites the whole register file once the block has gone quiet.
    task automatic apply_settings(logic [COUNT_REG_W-1:0] count, logic [SETUP_W-1:0] s0,
                                  logic [SETUP_W-1:0] s1, logic [SETUP_W-1:0] s2,
                                  logic [SETUP_W-1:0] s3);
        drain();
        write_register(REG_DEVICE_COUNT, DATA_W'(count));
        write_register(REG_DEV0_SETUP, DATA_W'(s0));
        write_register(REG_DEV0_SETUP + 3'd1, DATA_W'(s1));
        write_register(REG_DEV0_SETUP + 3'd2, DATA_W'(s2));
        write_register(REG_DEV3_SETUP, DATA_W'(s3));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Small batches and capacities keep the devices hovering around full, so
    // queries, oversubscription and underflow all happen often. Now and then
    // a setup takes a fully random value so every register bit toggles.
    function automatic logic [SETUP_W-1:0] random_setup();
        logic [SETUP_W-1:0] s;
        if ($urandom_range(0, 7) == 0)
            s = SETUP_W'({$urandom, $urandom});
        else
            s = {16'($urandom_range(0, 3)), 16'($urandom_range(0, 30)),
                 16'($urandom_range(0, 6))};
        return s;
    endfunction

    // Most items are queries, dispatches and completions with small amounts;
    // a few carry a full-width amount or the unused function code.
    task automatic send_random_item();
        int                 pick;
        func_t              f;
        logic [FIELD_W-1:0] amt;
        pick = $urandom_range(0, 15);
        if (pick < 5)
            f = FUNC_QUERY;
        else if (pick < 10)
            f = FUNC_DISPATCH;
        else if (pick < 15)
            f = FUNC_COMPLETE;
        else
            f = FUNC_NONE;
        amt = ($urandom_range(0, 7) == 0) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(0, 8));
        send_command(f, DEV_W'($urandom_range(0, 3)), amt);
    endtask

    initial
    begin
        // Device counts for the random phases, with the extremes and an
        // out-of-range value among them.
        logic [COUNT_REG_W-1:0] phase_count [RANDOM_PHASES];

        phase_count = '{3'd4, 3'd1, 3'd3, 3'd7, 3'd2, 3'd4, 3'd0, 3'd4};
        ledger = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset setups: batch 1, capacity 1, priority 1 on all four devices.
        // Fill device 0, watch the query move on, then hit both error cases.
        send_command(FUNC_QUERY, 2'd0, 16'd0);
        send_command(FUNC_DISPATCH, 2'd0, 16'd1);
        send_command(FUNC_QUERY, 2'd0, 16'd0);
        send_command(FUNC_DISPATCH, 2'd1, 16'd2);
        send_command(FUNC_COMPLETE, 2'd0, 16'd2);
        send_command(FUNC_NONE, 2'd3, 16'hFFFF);
        send_command(FUNC_DISPATCH, 2'd3, 16'd1);
        send_command(FUNC_COMPLETE, 2'd0, 16'd1);
        send_command(FUNC_QUERY, 2'd0, 16'd0);

        // With no device in use nothing is found, every device is unknown,
        // and the loaded device 3 does not spoil the idle flag.
        apply_settings(3'd0, SETUP_RESET, SETUP_RESET, SETUP_RESET, SETUP_RESET);
        send_command(FUNC_QUERY, 2'd0, 16'd0);
        send_command(FUNC_DISPATCH, 2'd0, 16'd1);
        send_command(FUNC_COMPLETE, 2'd3, 16'd1);

        // Two devices: device 2 is out of range, device 3 is still ignored.
        apply_settings(3'd2, SETUP_RESET, SETUP_RESET, SETUP_RESET, SETUP_RESET);
        send_command(FUNC_DISPATCH, 2'd2, 16'd1);
        send_command(FUNC_QUERY, 2'd0, 16'd0);

        // Count above four saturates. Device 0 is all ones, device 1 all
        // zeros, device 2 shares the top priority with zero batch and
        // capacity, device 3 is a plain middle setting.
        apply_settings(3'd7, 48'hFFFF_FFFF_FFFF, 48'h0, 48'hFFFF_0000_0000,
                       48'h0002_0005_0001);
        send_command(FUNC_DISPATCH, 2'd0, 16'hFFFF);
        // One more unit runs past both the capacity and the counter width.
        send_command(FUNC_DISPATCH, 2'd0, 16'd1);
        send_command(FUNC_QUERY, 2'd0, 16'd0);
        send_command(FUNC_COMPLETE, 2'd0, 16'hFFFF);
        // Devices 0 and 2 now tie on priority; the lower index must win.
        send_command(FUNC_QUERY, 2'd0, 16'd0);
        send_command(FUNC_DISPATCH, 2'd1, 16'd0);
        send_command(FUNC_COMPLETE, 2'd3, 16'd1);

        // Random phases, each under its own register settings. Halfway through
        // every phase the sender waits for all outstanding results.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_settings(phase_count[p], random_setup(), random_setup(),
                           random_setup(), random_setup());
            no_gaps = (p % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2) drain();
                send_random_item();
            end
        end
        no_gaps = 1'b0;

        drain();
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("tb_capacity_priority_dispatch_arbiter_top: done, clean");
        else
            $display("tb_capacity_priority_dispatch_arbiter_top: done, errors");
        $finish;
    end

endmodule
